// ----- design/mrope_pkg.sv -----
// ----------------------------------------------------------------------------
// mrope_pkg
// Shared types, constants and register codes of the multi-axis rotary unit.
// ----------------------------------------------------------------------------
package mrope_pkg;

	// table geometry (both powers of two: the address is {row, pair})
	localparam int MAX_POSITIONS = 1024;
	localparam int MAX_PAIRS     = 64;
	localparam int POS_W         = 10;
	localparam int PAIR_W        = 6;
	localparam int ADDR_W        = POS_W + PAIR_W;
	localparam int TABLE_DEPTH   = MAX_POSITIONS * MAX_PAIRS;

	// payload widths
	localparam int DATA_W  = 16;
	localparam int ENTRY_W = 2 * DATA_W;
	localparam int CNT_W   = 7;
	localparam int LIM_W   = 11;
	localparam int CSUM_W  = CNT_W + 1;

	// arithmetic: Q4.11 x Q1.14 -> Q5.25, round half up back to Q4.11
	localparam int PROD_W     = 2 * DATA_W;
	localparam int ACC_W      = PROD_W + 2;
	localparam int FRAC_SHIFT = 14;
	localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(2 ** (FRAC_SHIFT - 1));
	localparam logic signed [ACC_W-1:0] SAT_MAX    = ACC_W'((2 ** (DATA_W - 1)) - 1);
	localparam logic signed [ACC_W-1:0] SAT_MIN    = -SAT_MAX - 1;

	// apb register file
	localparam int APB_ADDR_W = 5;
	localparam int APB_DATA_W = 32;
	localparam int REG_IDX_W  = 3;
	localparam logic [LIM_W-1:0] LIMIT_RESET = 11'd1024;

	typedef enum logic {
		OP_ROTATE = 1'b0,
		OP_LOAD   = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		AXIS_TIME   = 2'd0,
		AXIS_HEIGHT = 2'd1,
		AXIS_WIDTH  = 2'd2,
		AXIS_NONE   = 2'd3
	} axis_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_PAIRS_TIME   = 3'd0,
		REG_PAIRS_HEIGHT = 3'd1,
		REG_PAIRS_WIDTH  = 3'd2,
		REG_LIMIT_TIME   = 3'd3,
		REG_LIMIT_HEIGHT = 3'd4,
		REG_LIMIT_WIDTH  = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [CNT_W-1:0] pairs_time;
		logic [CNT_W-1:0] pairs_height;
		logic [CNT_W-1:0] pairs_width;
		logic [LIM_W-1:0] limit_time;
		logic [LIM_W-1:0] limit_height;
		logic [LIM_W-1:0] limit_width;
	} cfg_regs_t;

	// axis decision for one rotate transaction
	typedef struct packed {
		axis_t             axis;
		logic              err;
		logic              bypass;
		logic [ADDR_W-1:0] addr;
	} sel_t;

	// sideband that travels with a table read
	typedef struct packed {
		logic signed [DATA_W-1:0] x_even;
		logic signed [DATA_W-1:0] x_odd;
		axis_t                    axis;
		logic                     err;
		logic                     bypass;
	} issue_t;

endpackage

// ----- design/mrope_if.sv -----
// ----------------------------------------------------------------------------
// mrope_in_if / mrope_out_if
// Valid/ready channels carrying input and result transactions.
// ----------------------------------------------------------------------------
interface mrope_in_if;
	logic                                       valid;
	logic                                       ready;
	mrope_pkg::op_t                             op;
	logic signed [mrope_pkg::DATA_W-1:0]        x_even;
	logic signed [mrope_pkg::DATA_W-1:0]        x_odd;
	logic        [mrope_pkg::PAIR_W-1:0]        pair_index;
	logic        [mrope_pkg::POS_W-1:0]         pos_time;
	logic        [mrope_pkg::POS_W-1:0]         pos_height;
	logic        [mrope_pkg::POS_W-1:0]         pos_width;
	logic        [mrope_pkg::POS_W-1:0]         table_row;
	logic signed [mrope_pkg::DATA_W-1:0]        cos_value;
	logic signed [mrope_pkg::DATA_W-1:0]        sin_value;

	modport source (
		output valid, op, x_even, x_odd, pair_index, pos_time, pos_height, pos_width,
		       table_row, cos_value, sin_value,
		input  ready
	);
	modport sink (
		input  valid, op, x_even, x_odd, pair_index, pos_time, pos_height, pos_width,
		       table_row, cos_value, sin_value,
		output ready
	);
endinterface

interface mrope_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [mrope_pkg::DATA_W-1:0] y_even;
	logic signed [mrope_pkg::DATA_W-1:0] y_odd;
	mrope_pkg::axis_t                    axis_used;
	logic                                range_error;
	logic                                saturated;

	modport source (
		output valid, y_even, y_odd, axis_used, range_error, saturated,
		input  ready
	);
	modport sink (
		input  valid, y_even, y_odd, axis_used, range_error, saturated,
		output ready
	);
endinterface

// ----- design/mrope_ram.sv -----
// ----------------------------------------------------------------------------
// mrope_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mrope_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- design/mrope_cfg.sv -----
// ----------------------------------------------------------------------------
// mrope_cfg
// APB register file holding the pair counts and position limits.
// ----------------------------------------------------------------------------
module mrope_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [mrope_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [mrope_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [mrope_pkg::APB_DATA_W-1:0]    prdata,
	output logic                                pready,
	output mrope_pkg::cfg_regs_t                cfg
);

	mrope_pkg::cfg_regs_t cfg_q;
	mrope_pkg::reg_idx_t  idx;
	logic                 wr_en;

	assign pready = 1'b1;
	assign idx    = mrope_pkg::reg_idx_t'(paddr[mrope_pkg::APB_ADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pairs_time   <= '0;
			cfg_q.pairs_height <= '0;
			cfg_q.pairs_width  <= '0;
			cfg_q.limit_time   <= mrope_pkg::LIMIT_RESET;
			cfg_q.limit_height <= mrope_pkg::LIMIT_RESET;
			cfg_q.limit_width  <= mrope_pkg::LIMIT_RESET;
		end else if (wr_en) begin
			unique case (idx)
				mrope_pkg::REG_PAIRS_TIME:   cfg_q.pairs_time   <= pwdata[mrope_pkg::CNT_W-1:0];
				mrope_pkg::REG_PAIRS_HEIGHT: cfg_q.pairs_height <= pwdata[mrope_pkg::CNT_W-1:0];
				mrope_pkg::REG_PAIRS_WIDTH:  cfg_q.pairs_width  <= pwdata[mrope_pkg::CNT_W-1:0];
				mrope_pkg::REG_LIMIT_TIME:   cfg_q.limit_time   <= pwdata[mrope_pkg::LIM_W-1:0];
				mrope_pkg::REG_LIMIT_HEIGHT: cfg_q.limit_height <= pwdata[mrope_pkg::LIM_W-1:0];
				mrope_pkg::REG_LIMIT_WIDTH:  cfg_q.limit_width  <= pwdata[mrope_pkg::LIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			mrope_pkg::REG_PAIRS_TIME:   prdata = 32'(cfg_q.pairs_time);
			mrope_pkg::REG_PAIRS_HEIGHT: prdata = 32'(cfg_q.pairs_height);
			mrope_pkg::REG_PAIRS_WIDTH:  prdata = 32'(cfg_q.pairs_width);
			mrope_pkg::REG_LIMIT_TIME:   prdata = 32'(cfg_q.limit_time);
			mrope_pkg::REG_LIMIT_HEIGHT: prdata = 32'(cfg_q.limit_height);
			mrope_pkg::REG_LIMIT_WIDTH:  prdata = 32'(cfg_q.limit_width);
			default:                     prdata = '0;
		endcase
	end

endmodule

// ----- design/mrope_sel.sv -----
// ----------------------------------------------------------------------------
// mrope_sel
// Picks the axis of a pair, checks its position and forms the table address.
// ----------------------------------------------------------------------------
module mrope_sel (
	input  mrope_pkg::cfg_regs_t             cfg,
	input  logic [mrope_pkg::PAIR_W-1:0]     pair_index,
	input  logic [mrope_pkg::POS_W-1:0]      pos_time,
	input  logic [mrope_pkg::POS_W-1:0]      pos_height,
	input  logic [mrope_pkg::POS_W-1:0]      pos_width,
	output mrope_pkg::sel_t                  sel
);

	logic [mrope_pkg::CSUM_W-1:0] end_time;
	logic [mrope_pkg::CSUM_W-1:0] end_height;
	logic [mrope_pkg::CSUM_W-1:0] end_width;
	logic [mrope_pkg::CSUM_W-1:0] pair_ext;
	logic [mrope_pkg::POS_W-1:0]  pos;
	logic [mrope_pkg::LIM_W-1:0]  limit;
	mrope_pkg::axis_t             axis;
	logic                         err;

	// sub-range ends, each one past the last pair of its axis
	assign end_time   = mrope_pkg::CSUM_W'(cfg.pairs_time);
	assign end_height = end_time + mrope_pkg::CSUM_W'(cfg.pairs_height);
	assign end_width  = end_height + mrope_pkg::CSUM_W'(cfg.pairs_width);
	assign pair_ext   = mrope_pkg::CSUM_W'(pair_index);

	always_comb begin
		priority if (32'(pair_index) >= mrope_pkg::MAX_PAIRS) axis = mrope_pkg::AXIS_NONE;
		else if (pair_ext < end_time)                          axis = mrope_pkg::AXIS_TIME;
		else if (pair_ext < end_height)                        axis = mrope_pkg::AXIS_HEIGHT;
		else if (pair_ext < end_width)                         axis = mrope_pkg::AXIS_WIDTH;
		else                                                   axis = mrope_pkg::AXIS_NONE;
	end

	always_comb begin
		unique case (axis)
			mrope_pkg::AXIS_TIME: begin
				pos   = pos_time;
				limit = cfg.limit_time;
			end
			mrope_pkg::AXIS_HEIGHT: begin
				pos   = pos_height;
				limit = cfg.limit_height;
			end
			default: begin
				pos   = pos_width;
				limit = cfg.limit_width;
			end
		endcase
	end

	assign err = (axis != mrope_pkg::AXIS_NONE) &&
		((mrope_pkg::LIM_W'(pos) >= limit) || (32'(pos) >= mrope_pkg::MAX_POSITIONS));

	assign sel.axis   = axis;
	assign sel.err    = err;
	assign sel.bypass = (axis == mrope_pkg::AXIS_NONE) || err;
	assign sel.addr   = {pos, pair_index};

endmodule

// ----- design/mrope_dp.sv -----
// ----------------------------------------------------------------------------
// mrope_dp
// Rotation pipeline: table data, products, round/saturate or bypass to output.
// ----------------------------------------------------------------------------
module mrope_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                issue,
	input  mrope_pkg::issue_t                   issue_info,
	input  logic [mrope_pkg::ENTRY_W-1:0]       entry,
	input  logic                                out_ready,
	output logic                                accept_ok,
	output logic                                out_valid,
	output logic signed [mrope_pkg::DATA_W-1:0] y_even,
	output logic signed [mrope_pkg::DATA_W-1:0] y_odd,
	output mrope_pkg::axis_t                    axis_used,
	output logic                                range_error,
	output logic                                saturated
);

	logic                                v_s1, v_s2, out_valid_q;
	logic                                out_en, adv_s2;
	mrope_pkg::issue_t                   info_s1, info_s2;
	logic signed [mrope_pkg::DATA_W-1:0] cos_s1, sin_s1;
	logic signed [mrope_pkg::PROD_W-1:0] p_ec_s2, p_os_s2, p_es_s2, p_oc_s2;
	logic signed [mrope_pkg::ACC_W-1:0]  acc_e, acc_o;
	logic [mrope_pkg::DATA_W:0]          res_e, res_o;

	function automatic logic [mrope_pkg::DATA_W:0] round_clip(
		input logic signed [mrope_pkg::ACC_W-1:0] acc
	);
		logic signed [mrope_pkg::ACC_W-1:0] q;
		q = (acc + mrope_pkg::ROUND_BIAS) >>> mrope_pkg::FRAC_SHIFT;
		priority if (q > mrope_pkg::SAT_MAX)
			return {1'b1, mrope_pkg::SAT_MAX[mrope_pkg::DATA_W-1:0]};
		else if (q < mrope_pkg::SAT_MIN)
			return {1'b1, mrope_pkg::SAT_MIN[mrope_pkg::DATA_W-1:0]};
		else
			return {1'b0, q[mrope_pkg::DATA_W-1:0]};
	endfunction

	// stall chain
	assign out_en    = !out_valid_q || out_ready;
	assign adv_s2    = !v_s2 || out_en;
	assign accept_ok = !v_s1 || adv_s2;

	assign cos_s1 = entry[mrope_pkg::DATA_W-1:0];
	assign sin_s1 = entry[mrope_pkg::ENTRY_W-1:mrope_pkg::DATA_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept_ok) begin
				v_s1 <= issue;
			end
			if (adv_s2) begin
				v_s2 <= v_s1;
			end
			if (out_en) begin
				out_valid_q <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			info_s1 <= issue_info;
		end
		if (adv_s2 && v_s1) begin
			info_s2 <= info_s1;
			p_ec_s2 <= mrope_pkg::PROD_W'(info_s1.x_even) * mrope_pkg::PROD_W'(cos_s1);
			p_os_s2 <= mrope_pkg::PROD_W'(info_s1.x_odd) * mrope_pkg::PROD_W'(sin_s1);
			p_es_s2 <= mrope_pkg::PROD_W'(info_s1.x_even) * mrope_pkg::PROD_W'(sin_s1);
			p_oc_s2 <= mrope_pkg::PROD_W'(info_s1.x_odd) * mrope_pkg::PROD_W'(cos_s1);
		end
	end

	assign acc_e = mrope_pkg::ACC_W'(p_ec_s2) - mrope_pkg::ACC_W'(p_os_s2);
	assign acc_o = mrope_pkg::ACC_W'(p_es_s2) + mrope_pkg::ACC_W'(p_oc_s2);
	assign res_e = round_clip(acc_e);
	assign res_o = round_clip(acc_o);

	always_ff @(posedge clk) begin
		if (out_en && v_s2) begin
			axis_used   <= info_s2.axis;
			range_error <= info_s2.err;
			if (info_s2.bypass) begin
				y_even    <= info_s2.x_even;
				y_odd     <= info_s2.x_odd;
				saturated <= 1'b0;
			end else begin
				y_even    <= res_e[mrope_pkg::DATA_W-1:0];
				y_odd     <= res_o[mrope_pkg::DATA_W-1:0];
				saturated <= res_e[mrope_pkg::DATA_W] || res_o[mrope_pkg::DATA_W];
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ----- design/multi_axis_rotary_embedding_unit.sv -----
// ----------------------------------------------------------------------------
// multi_axis_rotary_embedding_unit
// Rotates one even/odd pair of an attention head by a cos/sin entry of a
// position table, the position taken from the time, height or width axis.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake              carries
//  -------  ---  ---------------------  -------------------------------------
//  in       in   valid/ready            rotate or table-load transaction
//  out      out  valid/ready            rotated pair, axis, error/sat flags
//  apb      in   psel/penable, pready   pair counts and position limits
//
//  one transaction per cycle in and out unless out stalls; the single table
//  read port sets it; a rotate is registered through read, multiply, round
//  loads write the table at acceptance and return nothing
//  out stalls back up through the pipeline; in.ready drops only when all
//  three stages are full
//  reset clears control and config; the table is not cleared (no sweep)
//
module multi_axis_rotary_embedding_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [mrope_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [mrope_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [mrope_pkg::APB_DATA_W-1:0]   prdata,
	output logic                               pready,
	mrope_in_if.sink                           in,
	mrope_out_if.source                        out
);

	mrope_pkg::cfg_regs_t               cfg;
	mrope_pkg::sel_t                    sel;
	mrope_pkg::issue_t                  issue_info;
	logic                               accept_ok;
	logic                               in_fire;
	logic                               rot_issue;
	logic                               load_we;
	logic [mrope_pkg::ENTRY_W-1:0]      entry;

	// register file
	mrope_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// axis choice and table address, settled in the accept cycle
	mrope_sel u_sel (
		.cfg        (cfg),
		.pair_index (in.pair_index),
		.pos_time   (in.pos_time),
		.pos_height (in.pos_height),
		.pos_width  (in.pos_width),
		.sel        (sel)
	);

	assign in.ready  = accept_ok;
	assign in_fire   = in.valid && accept_ok;
	assign rot_issue = in_fire && (in.op == mrope_pkg::OP_ROTATE);

	// loads outside the table are dropped
	assign load_we = in_fire && (in.op == mrope_pkg::OP_LOAD) &&
		(32'(in.table_row) < mrope_pkg::MAX_POSITIONS) &&
		(32'(in.pair_index) < mrope_pkg::MAX_PAIRS);

	// a load and a read never share a cycle, and a read issued after a
	// load sees its data, so the table needs no forwarding path
	mrope_ram #(
		.WIDTH (mrope_pkg::ENTRY_W),
		.DEPTH (mrope_pkg::TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (load_we),
		.waddr ({in.table_row, in.pair_index}),
		.wdata ({in.sin_value, in.cos_value}),
		.re    (rot_issue),
		.raddr (sel.addr),
		.rdata (entry)
	);

	// sideband riding along with the table read
	assign issue_info.x_even = in.x_even;
	assign issue_info.x_odd  = in.x_odd;
	assign issue_info.axis   = sel.axis;
	assign issue_info.err    = sel.err;
	assign issue_info.bypass = sel.bypass;

	mrope_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.issue       (rot_issue),
		.issue_info  (issue_info),
		.entry       (entry),
		.out_ready   (out.ready),
		.accept_ok   (accept_ok),
		.out_valid   (out.valid),
		.y_even      (out.y_even),
		.y_odd       (out.y_odd),
		.axis_used   (out.axis_used),
		.range_error (out.range_error),
		.saturated   (out.saturated)
	);

endmodule

// ----- design/mrope_chk.sv -----
// ----------------------------------------------------------------------------
// mrope_chk
// Port-level checks of the rotary unit, bound onto the top level.
// ----------------------------------------------------------------------------
module mrope_chk (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic                                in_ready,
	input  mrope_pkg::op_t                      in_op,
	input  logic                                out_valid,
	input  logic                                out_ready,
	input  logic signed [mrope_pkg::DATA_W-1:0] y_even,
	input  logic signed [mrope_pkg::DATA_W-1:0] y_odd,
	input  mrope_pkg::axis_t                    axis_used,
	input  logic                                range_error,
	input  logic                                saturated
);

	// a result held under stall keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(y_even) && $stable(y_odd))
		else $error("result changed while stalled");

	// a fresh result after an empty output matches an accepted rotate transaction
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready && (in_op == mrope_pkg::OP_ROTATE), 3))
		else $error("result without matching rotate transaction");

	// pairs outside every axis carry no flags
	a_none_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (axis_used == mrope_pkg::AXIS_NONE) |-> !range_error && !saturated)
		else $error("flag set on pass-through pair");

	// an out-of-range pair is not rotated, so cannot saturate
	a_err_nosat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && range_error |-> !saturated)
		else $error("saturation on range error");

endmodule

bind multi_axis_rotary_embedding_unit mrope_chk u_mrope_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in.valid),
	.in_ready    (in.ready),
	.in_op       (in.op),
	.out_valid   (out.valid),
	.out_ready   (out.ready),
	.y_even      (out.y_even),
	.y_odd       (out.y_odd),
	.axis_used   (out.axis_used),
	.range_error (out.range_error),
	.saturated   (out.saturated)
);
